FILE: hw/rtl/tdcsd_pkg.sv
`default_nettype none

package tdcsd_pkg;

	localparam int WORD_BITS  = 16;
	localparam int POS_W      = $clog2(WORD_BITS);
	localparam int VALUE_W    = 7;
	localparam int PERIOD_W   = 16;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	localparam logic [VALUE_W-1:0]  MAX_VALUE    = 7'd99;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		PH_WAIT  = 2'd0,
		PH_SHIFT = 2'd1,
		PH_LATCH = 2'd2
	} phase_t;

	// segment lines per digit, bit i drives line i of the digit byte
	localparam logic [7:0] SEG_TABLE [10] = '{
		8'hBB, 8'h0A, 8'h73, 8'h5B, 8'hCA, 8'hD9, 8'hFD, 8'h0B, 8'hFB, 8'hDF
	};

	// n in 0..99: tens by reciprocal multiply (205/2048), tens digit in the high byte
	function automatic logic [WORD_BITS-1:0] seg_encode(input logic [VALUE_W-1:0] n);
		logic [14:0]        prod;
		logic [3:0]         tens;
		logic [VALUE_W-1:0] tens_x10;
		logic [3:0]         ones;
		prod     = 15'(n) * 15'd205;
		tens     = prod[14:11];
		tens_x10 = 7'(tens) * 7'd10;
		ones     = 4'(n - tens_x10);
		return {SEG_TABLE[tens], SEG_TABLE[ones]};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/two_digit_counter_shift_display.sv
// Two-digit counter feeding a seven-segment display through an external
// shift register.
// Input stream (s_axis_*): one item per timer tick or per set-value.
//   tuser[0] selects the kind (0 tick, 1 set-value), tdata[6:0] carries the
//   number 0..99 for a set-value. The first set-value loads the counter and
//   starts the block; later ones override the value shown in the next frame.
//   Set-values above 99 are dropped.
// Output stream (m_axis_*): exactly one item per input item, giving the
//   serial bit, shift pulse, latch pulse, frame start and shown value for
//   that tick (all pulses low on a set-value item).
// Config channel (cfg_*): writes frame_period, always ready. Write only
//   while no item is in flight.
// Each item passes through the input register, then the result register;
//   the next state is computed combinationally between them. Throughput: one
//   item per cycle while the receiver keeps m_axis_tready high.
// Reset empties both registers and resets all state; frame_period returns to 1000.
// When the receiver stalls, the result register holds and the input
// register fills, then s_axis_tready drops until the result is taken.
`default_nettype none

module two_digit_counter_shift_display (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [tdcsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [6:0] value, [7] zero
	input  wire logic [0:0]                            s_axis_tuser,  // [0] opcode
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output logic [tdcsd_pkg::OUT_DATA_W-1:0]           m_axis_tdata,  // [0] serial_data,
	                                                                  // [1] shift_pulse,
	                                                                  // [2] latch_pulse,
	                                                                  // [3] frame_start,
	                                                                  // [10:4] shown_value
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [tdcsd_pkg::PERIOD_W-1:0]        cfg_data
);

	localparam int VW = tdcsd_pkg::VALUE_W;
	localparam int PW = tdcsd_pkg::PERIOD_W;
	localparam int WB = tdcsd_pkg::WORD_BITS;
	localparam int BW = tdcsd_pkg::POS_W;

	// input register
	logic          valid_s1;
	logic          opcode_s1;
	logic [VW-1:0] value_s1;

	// output register
	logic                                m_valid_q;
	logic [tdcsd_pkg::OUT_DATA_W-1:0]    m_data_q;

	// block state
	logic [PW-1:0]      frame_period_q;
	logic               running_q,  running_d;
	logic [VW-1:0]      count_q,    count_d;
	logic               ovr_pend_q, ovr_pend_d;
	logic [VW-1:0]      ovr_num_q,  ovr_num_d;
	logic [PW-1:0]      tick_cnt_q, tick_cnt_d;
	logic [WB-1:0]      seg_word_q, seg_word_d;
	logic [BW-1:0]      bit_pos_q,  bit_pos_d;
	tdcsd_pkg::phase_t  phase_q,    phase_d;
	logic [VW-1:0]      shown_q,    shown_d;

	// result of the current item
	logic sdata, spulse, lpulse, fstart;

	logic adv;

	// stage 1 moves into the result register when that is empty or being drained
	assign adv           = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= s_axis_tuser[0];
			value_s1  <= s_axis_tdata[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= tdcsd_pkg::PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frame_period_q <= cfg_data;
		end
	end

	// next state and result for the item in stage 1
	always_comb begin
		logic [PW:0]        next_tick;
		logic [VW-1:0]      show;
		tdcsd_pkg::phase_t  ph_mid;
		logic [WB-1:0]      word_mid;
		logic [BW-1:0]      pos_mid;
		running_d  = running_q;
		count_d    = count_q;
		ovr_pend_d = ovr_pend_q;
		ovr_num_d  = ovr_num_q;
		tick_cnt_d = tick_cnt_q;
		seg_word_d = seg_word_q;
		bit_pos_d  = bit_pos_q;
		phase_d    = phase_q;
		shown_d    = shown_q;
		sdata      = 1'b0;
		spulse     = 1'b0;
		lpulse     = 1'b0;
		fstart     = 1'b0;
		next_tick  = {1'b0, tick_cnt_q} + {{PW{1'b0}}, 1'b1};
		show       = count_q;
		ph_mid     = phase_q;
		word_mid   = seg_word_q;
		pos_mid    = bit_pos_q;

		if (opcode_s1 == tdcsd_pkg::OP_SET) begin
			if (value_s1 <= tdcsd_pkg::MAX_VALUE) begin
				if (!running_q) begin
					count_d    = value_s1;
					running_d  = 1'b1;
					// arm so the next tick opens a frame
					tick_cnt_d = (frame_period_q == '0) ? '0
					                                    : frame_period_q - PW'(1);
				end else begin
					ovr_num_d  = value_s1;
					ovr_pend_d = 1'b1;
				end
			end
		end else begin
			if (next_tick >= {1'b0, frame_period_q}) begin
				tick_cnt_d = '0;
				if (running_q) begin
					if (ovr_pend_q) begin
						show       = ovr_num_q;
						ovr_pend_d = 1'b0;
					end
					count_d  = (count_q >= tdcsd_pkg::MAX_VALUE) ? '0 : count_q + VW'(1);
					shown_d  = show;
					word_mid = tdcsd_pkg::seg_encode(show);
					pos_mid  = BW'(WB - 1);
					ph_mid   = tdcsd_pkg::PH_SHIFT;
					fstart   = 1'b1;
				end
			end else begin
				tick_cnt_d = next_tick[PW-1:0];
			end

			seg_word_d = word_mid;
			bit_pos_d  = pos_mid;
			unique case (ph_mid)
				tdcsd_pkg::PH_SHIFT: begin
					sdata  = word_mid[pos_mid];
					spulse = 1'b1;
					if (pos_mid == '0) begin
						phase_d   = tdcsd_pkg::PH_LATCH;
						bit_pos_d = BW'(WB - 1);
					end else begin
						phase_d   = tdcsd_pkg::PH_SHIFT;
						bit_pos_d = pos_mid - BW'(1);
					end
				end
				tdcsd_pkg::PH_LATCH: begin
					lpulse  = 1'b1;
					phase_d = tdcsd_pkg::PH_WAIT;
				end
				default: begin
					phase_d = tdcsd_pkg::PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			count_q    <= '0;
			ovr_pend_q <= 1'b0;
			ovr_num_q  <= '0;
			tick_cnt_q <= '0;
			seg_word_q <= '0;
			bit_pos_q  <= BW'(WB - 1);
			phase_q    <= tdcsd_pkg::PH_WAIT;
			shown_q    <= '0;
		end else if (adv) begin
			running_q  <= running_d;
			count_q    <= count_d;
			ovr_pend_q <= ovr_pend_d;
			ovr_num_q  <= ovr_num_d;
			tick_cnt_q <= tick_cnt_d;
			seg_word_q <= seg_word_d;
			bit_pos_q  <= bit_pos_d;
			phase_q    <= phase_d;
			shown_q    <= shown_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_axis_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {5'b0, shown_d, fstart, lpulse, spulse, sdata};
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tdcsd_checker.sv
`default_nettype none

module tdcsd_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  s_axis_tvalid,
	input wire logic                                  s_axis_tready,
	input wire logic [tdcsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	input wire logic [0:0]                            s_axis_tuser,
	input wire logic                                  m_axis_tvalid,
	input wire logic                                  m_axis_tready,
	input wire logic [tdcsd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input wire logic                                  cfg_valid,
	input wire logic                                  cfg_ready,
	input wire logic [tdcsd_pkg::PERIOD_W-1:0]        cfg_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
		else $error("shift and latch in one item");

	a_data_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("serial bit without shift pulse");

	a_frame_shift: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1] && !m_axis_tdata[2])
		else $error("frame start without first shift");

	a_shown_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:4] <= tdcsd_pkg::MAX_VALUE)
		else $error("shown value out of range");

endmodule

bind two_digit_counter_shift_display tdcsd_checker u_tdcsd_checker (.*);

`default_nettype wire

FILE: tb/display_checker.sv
module display_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	input  wire logic                              s_axis_tready,
	input  wire logic [tdcsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [6:0] value, [7] zero
	input  wire logic [0:0]                        s_axis_tuser,   // [0] opcode
	input  wire logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	input  wire logic [tdcsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [0] serial_data,
	                                                               // [1] shift_pulse,
	                                                               // [2] latch_pulse,
	                                                               // [3] frame_start,
	                                                               // [10:4] shown_value
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [tdcsd_pkg::PERIOD_W-1:0]    cfg_data,
	output int unsigned                            mismatch_count,
	output int unsigned                            pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import tdcsd_pkg::*;

	localparam logic [6:0] TOP_NUMBER = 7'd99;
	localparam logic [3:0] LAST_BIT   = 4'd15;

	// segment byte per decimal digit, bit i is segment line i
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'hBB, 8'h0A, 8'h73, 8'h5B, 8'hCA, 8'hD9, 8'hFD, 8'h0B, 8'hFB, 8'hDF
	};

	// same bit order as m_axis_tdata[10:0]
	typedef struct packed {
		logic [6:0] shown;
		logic       frame_start;
		logic       latch;
		logic       shift;
		logic       serial;
	} display_out_t;

	logic [15:0] frame_period;
	logic        running;
	logic [6:0]  count_value;
	logic        override_pending;
	logic [6:0]  override_number;
	logic [15:0] tick_count;
	logic [15:0] segment_word;
	logic [3:0]  bit_pos;
	phase_t      shift_phase;
	logic [6:0]  last_shown;

	display_out_t expected_outputs[$];
	int unsigned  fails;

	function automatic display_out_t step_display(input opcode_t op, input logic [6:0] num);
		display_out_t r;
		logic [16:0]  next_ticks;
		logic [6:0]   show;
		r = '0;
		if (op == OP_SET) begin
			// numbers above 99 leave everything untouched
			if (num <= TOP_NUMBER) begin
				if (!running) begin
					count_value = num;
					running     = 1'b1;
					tick_count  = (frame_period == '0) ? '0 : frame_period - 16'd1;
				end else begin
					override_number  = num;
					override_pending = 1'b1;
				end
			end
		end else begin
			next_ticks = {1'b0, tick_count} + 17'd1;
			if (next_ticks >= {1'b0, frame_period}) begin
				tick_count = '0;
				if (running) begin
					if (override_pending) begin
						show             = override_number;
						override_pending = 1'b0;
					end else begin
						show = count_value;
					end
					count_value   = (count_value >= TOP_NUMBER) ? 7'd0 : count_value + 7'd1;
					last_shown    = show;
					segment_word  = {DIGIT_SEGS[(show / 10) % 10], DIGIT_SEGS[show % 10]};
					bit_pos       = LAST_BIT;
					shift_phase   = PH_SHIFT;
					r.frame_start = 1'b1;
				end
			end else begin
				tick_count = next_ticks[15:0];
			end

			case (shift_phase)
				PH_SHIFT: begin
					r.serial = segment_word[bit_pos];
					r.shift  = 1'b1;
					if (bit_pos == 4'd0) begin
						shift_phase = PH_LATCH;
						bit_pos     = LAST_BIT;
					end else begin
						bit_pos = bit_pos - 4'd1;
					end
				end
				PH_LATCH: begin
					r.latch     = 1'b1;
					shift_phase = PH_WAIT;
				end
				default: begin
					shift_phase = PH_WAIT;
				end
			endcase
		end
		r.shown = last_shown;
		return r;
	endfunction

	function automatic int field_wrong(input string name, input int exp_v, input int got_v);
		if (exp_v == got_v)
			return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		display_out_t exp_out;
		display_out_t got_out;
		if (!arst_n) begin
			frame_period     = PERIOD_RESET;
			running          = 1'b0;
			count_value      = '0;
			override_pending = 1'b0;
			override_number  = '0;
			tick_count       = '0;
			segment_word     = '0;
			bit_pos          = LAST_BIT;
			shift_phase      = PH_WAIT;
			last_shown       = '0;
			fails            = 0;
			expected_outputs.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				frame_period = cfg_data;

			// results first, so an item taken in this cycle cannot match itself
			if (m_axis_tvalid && m_axis_tready) begin
				got_out = display_out_t'(m_axis_tdata[10:0]);
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected item, expected none got %h", $time, m_axis_tdata);
					fails++;
				end else begin
					exp_out = expected_outputs.pop_front();
					fails += field_wrong("serial_data", exp_out.serial, got_out.serial);
					fails += field_wrong("shift_pulse", exp_out.shift, got_out.shift);
					fails += field_wrong("latch_pulse", exp_out.latch, got_out.latch);
					fails += field_wrong("frame_start", exp_out.frame_start, got_out.frame_start);
					fails += field_wrong("shown_value", exp_out.shown, got_out.shown);
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				expected_outputs.push_back(step_display(opcode_t'(s_axis_tuser[0]),
				                                        s_axis_tdata[6:0]));

			pending_count  <= expected_outputs.size();
			mismatch_count <= fails;
		end
	end

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tdcsd_pkg::*;

	// cycles with no accepted item before the run is called hung
	localparam int HANG_LIMIT   = 3000;
	// cycles left after the last result; two-stage pipe, so a few suffice
	localparam int SETTLE       = 6;
	localparam int LONG_HOLD    = 64;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 128;

	logic                      clk;
	logic                      arst_n        = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_DATA_W-1:0]      s_axis_tdata  = '0;   // [6:0] value, [7] zero
	logic [0:0]                s_axis_tuser  = '0;   // [0] opcode
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]     m_axis_tdata;         // [0] serial_data, [1] shift_pulse,
	                                                 // [2] latch_pulse, [3] frame_start,
	                                                 // [10:4] shown_value
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [PERIOD_W-1:0]       cfg_data      = '0;

	int unsigned               mismatch_count;
	int unsigned               pending_count;

	// gap control shared by both sides
	bit                        no_gaps       = 1'b0;
	int unsigned               holds_asked   = 0;
	int unsigned               holds_served  = 0;

	wire in_fire  = s_axis_tvalid && s_axis_tready;
	wire out_fire = m_axis_tvalid && m_axis_tready;

	two_digit_counter_shift_display DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	display_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Receiver: random stalls, plus one long hold whenever the stimulus asks.
	// Each edge sees at most one update of tready.
	always begin : sink
		int stall_len;
		@(posedge clk);
		if (holds_asked != holds_served) begin
			stall_len = LONG_HOLD;
			holds_served++;
		end else begin
			stall_len = pick_gap();
		end
		if (stall_len > 0) begin
			m_axis_tready <= 1'b0;
			repeat (stall_len) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
	end

	// Offer one item, with an optional gap before it, and wait for the accept.
	// Called at a clock edge; returns at the edge that took the item.
	task automatic send_item(input opcode_t op, input logic [6:0] num);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, num};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stop offering and wait until every outstanding result is back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] period);
		cfg_valid <= 1'b1;
		cfg_data  <= period;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic: ticks dominate so frames get shifted out in full;
	// set-values mostly in range, a few above 99 that must be dropped.
	task automatic random_items(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99, 0);
			if (r < 84)
				send_item(OP_TICK, 7'($urandom_range(127, 0)));
			else if (r < 96)
				send_item(OP_SET, 7'($urandom_range(99, 0)));
			else
				send_item(OP_SET, 7'($urandom_range(127, 100)));
		end
	endtask

	// Hang detector: only counts edges where neither side moved an item.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if (in_fire || out_fire)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("two_digit_counter_shift_display: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [PERIOD_W-1:0] period;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ticks while stopped at the reset period, then an
		// out-of-range start that must be ignored.
		send_item(OP_TICK, 7'd127);
		send_item(OP_TICK, 7'd0);
		send_item(OP_TICK, 7'd85);
		send_item(OP_SET, 7'd127);
		drain();

		// Longest period: the start arms the prescaler so the first tick
		// still frames. Override 99 goes on that frame, 100 is dropped.
		write_period(16'hFFFF);
		send_item(OP_SET, 7'd0);
		send_item(OP_SET, 7'd99);
		send_item(OP_SET, 7'd100);
		// 16 shift ticks, one latch tick, one idle tick
		for (int i = 0; i < 18; i++)
			send_item(OP_TICK, 7'(i));
		drain();

		// Periods around the 17-tick shift+latch window, plus zero and one.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: period = 16'd1;
				1: period = 16'd0;
				2: period = 16'd2;
				3: period = 16'd16;
				4: period = 16'd17;
				5: period = 16'd18;
				6: period = 16'd19;
				7: period = 16'd1;
				8: period = 16'd5;
				default: period = PERIOD_W'($urandom_range(40, 3));
			endcase
			write_period(period);
			no_gaps = (ph == 4 || ph == 8);
			// long receiver hold while items keep coming, so the input stalls
			if (ph == 3 || ph == 7)
				holds_asked++;
			random_items(PHASE_ITEMS);
			drain();
		end

		if (mismatch_count == 0)
			$display("two_digit_counter_shift_display: match");
		else
			$display("two_digit_counter_shift_display: mismatch");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/tdcsd_pkg.sv
hw/rtl/two_digit_counter_shift_display.sv
hw/rtl/tdcsd_checker.sv
tb/display_checker.sv
tb/testbench.sv
